>>> hdl/cef_pkg.sv
`timescale 1ns / 1ps
package cef_pkg;

	localparam int TASKS     = 16;
	localparam int FLAG_BITS = 16;
	localparam int NEST_BITS = 8;
	localparam int TASK_W    = 4;
	localparam int ACT_W     = 5;
	localparam int CMD_W     = 2;

	localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLR   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FETCH = 2'd2;

	localparam logic [NEST_BITS-1:0] NEST_MAX  = '1;
	localparam logic [NEST_BITS-1:0] NEST_ZERO = '0;

	localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

	typedef logic [NEST_BITS-1:0] nest_t;
	typedef logic [FLAG_BITS-1:0] flag_word_t;
	typedef logic [FLAG_BITS-1:0][NEST_BITS-1:0] cnt_row_t;
	typedef logic [TASKS-1:0][FLAG_BITS-1:0] flag_table_t;

	typedef struct packed {
		logic set_en;
		logic clr_en;
	} lane_ctrl_t;

	typedef struct packed {
		logic              found;
		logic [TASK_W-1:0] task_idx;
		flag_word_t        flags;
	} fetch_res_t;

endpackage

>>> hdl/counted_event_flag_table.sv
`timescale 1ns / 1ps
// Counted event flag table.
// Input words arrive on s_tvalid/s_tready with the command in s_tuser and the
// task index and event mask in s_tdata. Each input word yields exactly one
// result word on m_tvalid/m_tready carrying status, found, found_task and
// found_flags.
// A word is taken into a first stage that reads the task's row of nesting
// counters from the counter store; once the output register is free or being
// read, sixteen lanes update the counters of that row, the row and the flag
// word are written back, and the result is loaded into the output register.
// A new word is not accepted while the first stage still holds the last one.
// When the receiver stalls, the result is held in the output register and the
// first stage still accepts one further word, which then waits until the
// output register is free.
// The active task count is written at APB address 0; the user must do so only
// while the block is idle, which it does not enforce. Reset clears all flag
// words, the control state and sets the active count to sixteen; the counter
// store needs no clearing: a counter reads zero while its flag is clear.
module counted_event_flag_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // task_index[3:0], event_mask[19:4], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status[0], found[1], found_task[5:2],
	                               // found_flags[21:6], zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cef_pkg::*;

	logic [ACT_W-1:0]  active_q;
	flag_table_t       flags_q;
	cnt_row_t          cnt_mem [TASKS];

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [TASK_W-1:0] task_s1;
	flag_word_t        mask_s1;
	cnt_row_t          row_s1;

	logic              out_valid_q;
	logic              status_q;
	fetch_res_t        res_q;

	logic              s_accept;
	logic              adv;
	logic              is_upd;
	logic              inval;
	logic              wr_en;
	lane_ctrl_t        ctrl;
	cnt_row_t          row_new;
	flag_word_t        word_new;
	fetch_res_t        fetch_res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {27'd0, active_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			active_q <= pwdata[ACT_W-1:0];
		end
	end

	assign s_tready = !valid_s1;
	assign s_accept = s_tvalid && s_tready;
	assign adv      = valid_s1 && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1  <= s_tuser;
			task_s1 <= s_tdata[3:0];
			mask_s1 <= s_tdata[19:4];
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			row_s1 <= cnt_mem[s_tdata[3:0]];
		end
		if (wr_en) begin
			cnt_mem[task_s1] <= row_new;
		end
	end

	assign is_upd      = (cmd_s1 == CMD_SET) || (cmd_s1 == CMD_CLR);
	assign inval       = is_upd && ({1'b0, task_s1} >= active_q);
	assign ctrl.set_en = (cmd_s1 == CMD_SET) && !inval;
	assign ctrl.clr_en = (cmd_s1 == CMD_CLR) && !inval;
	assign wr_en       = adv && is_upd && !inval;

	for (genvar b = 0; b < FLAG_BITS; b++) begin : g_lane
		cef_lane u_lane (
			.ctrl     (ctrl),
			.mask     (mask_s1[b]),
			.flag     (flags_q[task_s1][b]),
			.cnt      (row_s1[b]),
			.cnt_new  (row_new[b]),
			.flag_new (word_new[b])
		);
	end

	cef_fetch u_fetch (
		.flags  (flags_q),
		.active (active_q),
		.res    (fetch_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (wr_en) begin
			flags_q[task_s1] <= word_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= inval;
			res_q    <= (cmd_s1 == CMD_FETCH) ? fetch_res : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.flags, res_q.task_idx, res_q.found, status_q};

endmodule

>>> hdl/cef_lane.sv
`timescale 1ns / 1ps
module cef_lane (
	input  cef_pkg::lane_ctrl_t ctrl,
	input  logic                mask,
	input  logic                flag,
	input  cef_pkg::nest_t      cnt,
	output cef_pkg::nest_t      cnt_new,
	output logic                flag_new
);
	import cef_pkg::*;

	nest_t cnt_eff;
	nest_t cnt_dec;

	// A counter whose flag is clear holds zero, whatever the row store says.
	assign cnt_eff = flag ? cnt : NEST_ZERO;
	assign cnt_dec = (cnt_eff != NEST_ZERO) ? cnt_eff - 1'b1 : NEST_ZERO;

	always_comb begin
		cnt_new  = cnt_eff;
		flag_new = flag;
		if (ctrl.set_en && mask && (cnt_eff != NEST_MAX)) begin
			cnt_new  = cnt_eff + 1'b1;
			flag_new = 1'b1;
		end else if (ctrl.clr_en && mask && flag) begin
			cnt_new  = cnt_dec;
			flag_new = (cnt_dec != NEST_ZERO);
		end
	end

endmodule

>>> hdl/cef_fetch.sv
`timescale 1ns / 1ps
module cef_fetch (
	input  cef_pkg::flag_table_t     flags,
	input  logic [cef_pkg::ACT_W-1:0] active,
	output cef_pkg::fetch_res_t      res
);
	import cef_pkg::*;

	logic [TASKS-1:0]  pend;
	logic [TASK_W-1:0] first;

	always_comb begin
		for (int i = 0; i < TASKS; i++) begin
			pend[i] = (|flags[i]) && (ACT_W'(i) < active);
		end
	end

	always_comb begin
		first = '0;
		for (int i = TASKS - 1; i >= 0; i--) begin
			if (pend[i]) begin
				first = TASK_W'(i);
			end
		end
	end

	always_comb begin
		res.found    = |pend;
		res.task_idx = (|pend) ? first : '0;
		res.flags    = (|pend) ? flags[first] : '0;
	end

endmodule

>>> hdl/cef_checker.sv
`timescale 1ns / 1ps
module cef_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// Only one word is in the first stage at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while the first stage was occupied");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	a_invalid_bare: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[23:1] == 23'd0)
		else $error("invalid-task result carries fetch fields");

	a_none_bare: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[23:2] == 22'd0)
		else $error("result without a find carries a task or flags");

	a_found_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[21:6] != 16'd0 && !m_tdata[0])
		else $error("found task reported with an empty flag word");

endmodule

bind counted_event_flag_table cef_checker u_cef_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import cef_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] ACTIVE_TASKS_ADDR = 3'd0;

	typedef struct {
		logic              status;
		logic              found;
		logic [TASK_W-1:0] task_no;
		flag_word_t        flags;
	} table_result_t;

	class flag_table_board;
		flag_word_t       flags [TASKS];
		nest_t            counts [TASKS][FLAG_BITS];
		logic [ACT_W-1:0] active;
		table_result_t    expected_results[$];
		int errors;
		int words_in;
		int results_seen;
		int fetch_hits;
		int invalid_hits;
		int saturated_sets;
		int settings;

		function new();
			foreach (flags[t]) begin
				flags[t] = '0;
				foreach (counts[t][b]) counts[t][b] = NEST_ZERO;
			end
			active = ACTIVE_RESET;
			errors = 0;
			words_in = 0;
			results_seen = 0;
			fetch_hits = 0;
			invalid_hits = 0;
			saturated_sets = 0;
			settings = 1;
		endfunction

		function void write_active(logic [ACT_W-1:0] value);
			active = value;
			settings++;
		endfunction

		function void note_word(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] task_no,
				flag_word_t mask);
			table_result_t res;
			int limit;
			res = '{status: 1'b0, found: 1'b0, task_no: '0, flags: '0};
			limit = (active > TASKS) ? TASKS : int'(active);
			words_in++;
			if (cmd == CMD_SET || cmd == CMD_CLR) begin
				if (int'(task_no) >= limit) begin
					res.status = 1'b1;
					invalid_hits++;
				end else if (cmd == CMD_SET) begin
					for (int b = 0; b < FLAG_BITS; b++) begin
						if (mask[b]) begin
							if (counts[task_no][b] == NEST_MAX) begin
								saturated_sets++;
							end else begin
								counts[task_no][b]++;
								flags[task_no][b] = 1'b1;
							end
						end
					end
				end else begin
					for (int b = 0; b < FLAG_BITS; b++) begin
						if (mask[b] && flags[task_no][b]) begin
							if (counts[task_no][b] != NEST_ZERO) counts[task_no][b]--;
							if (counts[task_no][b] == NEST_ZERO) flags[task_no][b] = 1'b0;
						end
					end
				end
			end else if (cmd == CMD_FETCH) begin
				for (int t = 0; t < limit; t++) begin
					if (flags[t] != '0) begin
						res.found = 1'b1;
						res.task_no = t[TASK_W-1:0];
						res.flags = flags[t];
						fetch_hits++;
						break;
					end
				end
			end
			expected_results.push_back(res);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(logic [23:0] data);
			table_result_t want;
			table_result_t got;
			got.status = data[0];
			got.found = data[1];
			got.task_no = data[5:2];
			got.flags = data[21:6];
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t ns: unexpected result word, expected none, actual %06h",
					$time, data);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report("status", 32'(want.status), 32'(got.status));
				if (got.found !== want.found)
					report("found", 32'(want.found), 32'(got.found));
				if (got.task_no !== want.task_no)
					report("found_task", 32'(want.task_no), 32'(got.task_no));
				if (got.flags !== want.flags)
					report("found_flags", 32'(want.flags), 32'(got.flags));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // task_index[3:0], event_mask[19:4], zero pad
	logic [1:0]  s_tuser;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // status[0], found[1], found_task[5:2], found_flags[21:6]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        quiet;

	flag_table_board board;

	counted_event_flag_table u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic push_word(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] task_no,
			flag_word_t mask);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, mask, task_no};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		board.note_word(cmd, task_no, mask);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_active_tasks(logic [ACT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ACTIVE_TASKS_ADDR;
		pwdata <= {27'b0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_active(value);
		@(negedge clk);
		if (prdata !== {27'b0, value})
			board.report("active_tasks readback", {27'b0, value}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_traffic(int count, int span);
		int sent;
		int r;
		int depth;
		logic [CMD_W-1:0] cmd;
		logic [TASK_W-1:0] task_no;
		flag_word_t mask;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) task_no = TASK_W'($urandom_range(0, 15));
			else task_no = TASK_W'($urandom_range(0, span - 1));
			case ($urandom_range(0, 5))
				0: mask = '1;
				1: mask = flag_word_t'(1) << $urandom_range(0, FLAG_BITS - 1);
				2: mask = flag_word_t'($urandom & $urandom);
				3: mask = ($urandom_range(0, 3) == 0) ? '0 : flag_word_t'($urandom);
				default: mask = flag_word_t'($urandom);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				// Nested raise and release of the same bits, checked by fetches.
				depth = $urandom_range(1, 5);
				repeat (depth) push_word(CMD_SET, task_no, mask);
				push_word(CMD_FETCH, TASK_W'($urandom), flag_word_t'($urandom));
				repeat (depth) push_word(CMD_CLR, task_no, mask);
				push_word(CMD_FETCH, TASK_W'($urandom), flag_word_t'($urandom));
				sent += 2 * depth + 2;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 8) cmd = CMD_SET;
				else if (r < 15) cmd = CMD_CLR;
				else if (r < 19) cmd = CMD_FETCH;
				else cmd = CMD_UNUSED;
				push_word(cmd, task_no, mask);
				sent++;
			end
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && stall == 0 && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata);
	end

	initial begin
		#2000000;
		$display("counted_event_flag_table verification failed");
		$finish;
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		board = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_word(CMD_FETCH, 4'd0, '0);
		push_word(CMD_SET, 4'd0, 16'h0001);
		push_word(CMD_SET, 4'd15, 16'h8000);
		push_word(CMD_FETCH, 4'd15, 16'hFFFF);
		push_word(CMD_CLR, 4'd0, 16'h0001);
		push_word(CMD_FETCH, 4'd0, '0);
		push_word(CMD_CLR, 4'd3, 16'hFFFF);
		push_word(CMD_SET, 4'd5, 16'hFFFF);
		push_word(CMD_SET, 4'd5, 16'hFFFF);
		push_word(CMD_CLR, 4'd5, 16'hFFFF);
		push_word(CMD_FETCH, 4'd0, '0);
		push_word(CMD_UNUSED, 4'd15, 16'hFFFF);
		push_word(CMD_SET, 4'd9, 16'h0000);
		push_word(CMD_CLR, 4'd15, 16'h8000);
		push_word(CMD_SET, 4'd10, 16'hAAAA);
		push_word(CMD_SET, 4'd10, 16'h5555);
		push_word(CMD_FETCH, 4'd0, '0);
		drain();

		write_active_tasks(5'd0);
		push_word(CMD_SET, 4'd0, 16'hFFFF);
		push_word(CMD_CLR, 4'd15, 16'hFFFF);
		push_word(CMD_FETCH, 4'd0, '0);
		drain();

		write_active_tasks(5'd4);
		push_word(CMD_FETCH, 4'd0, '0);
		push_word(CMD_SET, 4'd4, 16'hFFFF);
		push_word(CMD_SET, 4'd3, 16'h0F0F);
		push_word(CMD_FETCH, 4'd0, '0);
		drain();

		write_active_tasks(5'd31);
		push_word(CMD_FETCH, 4'd0, '0);
		push_word(CMD_SET, 4'd15, 16'h1234);
		push_word(CMD_CLR, 4'd3, 16'h0F0F);
		push_word(CMD_FETCH, 4'd0, '0);
		drain();

		// Drive every counter of one task past its maximum.
		write_active_tasks(5'd16);
		repeat (258) push_word(CMD_SET, 4'd14, 16'hFFFF);
		push_word(CMD_SET, 4'd14, 16'h00FF);
		repeat (2) push_word(CMD_CLR, 4'd14, 16'h0001);
		push_word(CMD_FETCH, 4'd0, '0);
		drain();

		write_active_tasks(5'd1);
		random_traffic(70, 1);
		drain();
		write_active_tasks(5'd9);
		random_traffic(80, 9);
		drain();
		write_active_tasks(5'd16);
		random_traffic(90, 16);
		drain();
		guard = $urandom_range(1, 16);
		write_active_tasks(guard[ACT_W-1:0]);
		quiet = 1'b1;
		random_traffic(80, guard);

		s_tvalid <= 1'b0;
		guard = 0;
		while (board.expected_results.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (board.expected_results.size() != 0) begin
			$display("%0t ns: %0d results never arrived, expected 0 outstanding, actual %0d",
				$time, board.expected_results.size(), board.expected_results.size());
			board.errors++;
		end
		$display("Checked %0d results for %0d words over %0d task-count settings.",
			board.results_seen, board.words_in, board.settings);
		$display("Fetch hits: %0d, invalid-task statuses: %0d, saturated-bit sets: %0d.",
			board.fetch_hits, board.invalid_hits, board.saturated_sets);
		if (board.errors == 0) begin
			$display("counted_event_flag_table verification clean");
		end else begin
			$display("counted_event_flag_table verification failed");
		end
		$finish;
	end
endmodule
